### design/csrepl_pkg.sv
// ----------------------------------------------------------------------------
// csrepl_pkg
// Shared types and constants for the sparse-row entry position lookup block.
// ----------------------------------------------------------------------------
package csrepl_pkg;

    localparam int MAX_ROWS     = 1024;
    localparam int MAX_NONZEROS = 16384;
    localparam int COLUMN_BITS  = 16;

    localparam int KIND_W    = 2;
    localparam int SLOT_W    = 15;
    localparam int VALUE_W   = 16;
    localparam int ROW_W     = 10;
    localparam int COL_W     = 16;
    localparam int POS_W     = 14;
    localparam int STATUS_W  = 2;
    localparam int ROWCNT_W  = 11;
    localparam int OFFSET_W  = 15;
    localparam int ROWADDR_W = $clog2(MAX_ROWS + 1);
    localparam int COLADDR_W = $clog2(MAX_NONZEROS);
    localparam int PTR_W     = $clog2(MAX_NONZEROS + 1);

    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_WR_OFFSET = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WR_COLUMN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_FOUND   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ROW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT  = 2'd2;

    // input payload, last declared field (slot) in the lowest bits
    typedef struct packed {
        logic [S_DATA_W-SLOT_W-VALUE_W-ROW_W-COL_W-1:0] pad;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [VALUE_W-1:0] value;
        logic [SLOT_W-1:0]  slot;
    } s_data_t;

    typedef struct packed {
        logic                accept_lookup;
        logic                write_item;
        logic                load_begin;
        logic                load_end;
        logic                issue_probe;
        logic                apply_probe;
        logic                load_result;
        logic                result_search;
        logic [STATUS_W-1:0] result_code;
    } cmd_t;

    typedef struct packed {
        logic bad_row;
        logic empty;
        logic search_done;
    } stat_t;

endpackage

### design/csrepl_ctrl.sv
// ----------------------------------------------------------------------------
// csrepl_ctrl
// Sequencer for store writes and the lookup: offset reads, binary search probes, result load.
// ----------------------------------------------------------------------------
module csrepl_ctrl import csrepl_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [KIND_W-1:0] s_kind,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  stat_t             stat,
    output cmd_t              cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BEGIN  = 3'd1;
    localparam logic [2:0] S_END    = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_PROBE  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                search_reg, search_next;
    logic [STATUS_W-1:0] code_reg, code_next;
    logic                accept;
    logic                out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        search_next   = search_reg;
        code_next     = code_reg;
        cmd           = '0;
        cmd.result_search = search_reg;
        cmd.result_code   = code_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_WR_OFFSET || s_kind == KIND_WR_COLUMN) begin
                        cmd.write_item = 1'b1;
                    end else if (s_kind == KIND_LOOKUP) begin
                        cmd.accept_lookup = 1'b1;
                        if (stat.bad_row) begin
                            search_next = 1'b0;
                            code_next   = STATUS_BAD_ROW;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_BEGIN;
                        end
                    end
                end
            end
            S_BEGIN: begin
                cmd.load_begin = 1'b1;
                state_next     = S_END;
            end
            S_END: begin
                cmd.load_end = 1'b1;
                if (stat.empty) begin
                    search_next = 1'b0;
                    code_next   = STATUS_ABSENT;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (stat.search_done) begin
                    search_next = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    cmd.issue_probe = 1'b1;
                    state_next      = S_PROBE;
                end
            end
            S_PROBE: begin
                cmd.apply_probe = 1'b1;
                state_next      = S_SEARCH;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_result = 1'b1;
                    m_tvalid_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            search_reg   <= 1'b0;
            code_reg     <= STATUS_FOUND;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            search_reg   <= search_next;
            code_reg     <= code_next;
        end
    end

    // result only overwrites a register that is empty or being drained
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an untaken result");

    // a probe read is always followed by its compare
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue_probe |=> cmd.apply_probe)
        else $error("probe issued without compare");

    // at most one datapath step per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept_lookup, cmd.write_item, cmd.load_begin, cmd.load_end,
                  cmd.issue_probe, cmd.apply_probe, cmd.load_result}))
        else $error("conflicting datapath commands");

endmodule

### design/csrepl_dp.sv
// ----------------------------------------------------------------------------
// csrepl_dp
// Offset and column stores, search bounds, compare and result registers.
// ----------------------------------------------------------------------------
module csrepl_dp import csrepl_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [ROWCNT_W-1:0] cfg_data,
    input  logic [KIND_W-1:0]   s_kind,
    input  s_data_t             s_data,
    input  cmd_t                cmd,
    output stat_t               stat,
    output logic [POS_W-1:0]    m_position,
    output logic [STATUS_W-1:0] m_status
);

    logic [OFFSET_W-1:0]    off_mem [0:MAX_ROWS];
    logic [COLUMN_BITS-1:0] col_mem [0:MAX_NONZEROS-1];

    logic [ROWCNT_W-1:0]    row_count_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [COL_W-1:0]       col_reg;
    logic [OFFSET_W-1:0]    off_rd_reg;
    logic [COLUMN_BITS-1:0] col_rd_reg;
    logic [PTR_W-1:0]       lo_reg, hi_reg, end_reg, mid_reg;
    logic                   eq_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [STATUS_W-1:0]    status_reg;

    logic [ROWADDR_W-1:0]   off_addr;
    logic [PTR_W-1:0]       off_clamped;
    logic [PTR_W:0]         mid_sum;
    logic [PTR_W-1:0]       mid;
    logic                   col_below;
    logic                   found;

    function automatic logic [PTR_W-1:0] clamp_offset(input logic [OFFSET_W-1:0] off);
        logic [PTR_W-1:0] ext;
        ext = PTR_W'(off);
        return (ext > PTR_W'(MAX_NONZEROS)) ? PTR_W'(MAX_NONZEROS) : ext;
    endfunction

    assign off_addr    = cmd.accept_lookup ? ROWADDR_W'(s_data.row)
                                           : ROWADDR_W'(row_reg) + ROWADDR_W'(1);
    assign off_clamped = clamp_offset(off_rd_reg);
    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid         = mid_sum[PTR_W:1];
    assign col_below   = COL_W'(col_rd_reg) < col_reg;
    assign found       = (lo_reg != end_reg) && eq_reg;

    assign stat.bad_row = (ROWCNT_W'(s_data.row) >= row_count_reg)
                       || (ROWCNT_W'(s_data.row) >= ROWCNT_W'(MAX_ROWS));
    assign stat.empty       = lo_reg > off_clamped;
    assign stat.search_done = lo_reg >= hi_reg;

    assign m_position = pos_reg;
    assign m_status   = status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
        end else if (cfg_valid) begin
            row_count_reg <= cfg_data;
        end
    end

    // offset store
    always_ff @(posedge aclk) begin
        if (cmd.write_item && s_kind == KIND_WR_OFFSET
                && s_data.slot < SLOT_W'(MAX_ROWS + 1)) begin
            off_mem[s_data.slot[ROWADDR_W-1:0]] <= s_data.value[OFFSET_W-1:0];
        end
        off_rd_reg <= off_mem[off_addr];
    end

    // column store
    always_ff @(posedge aclk) begin
        if (cmd.write_item && s_kind == KIND_WR_COLUMN
                && s_data.slot < SLOT_W'(MAX_NONZEROS)) begin
            col_mem[s_data.slot[COLADDR_W-1:0]] <= s_data.value[COLUMN_BITS-1:0];
        end
        if (cmd.issue_probe) begin
            col_rd_reg <= col_mem[mid[COLADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept_lookup) begin
            row_reg <= s_data.row;
            col_reg <= s_data.col;
        end
        if (cmd.load_begin) begin
            lo_reg <= off_clamped;
        end
        if (cmd.load_end) begin
            hi_reg  <= off_clamped;
            end_reg <= off_clamped;
        end
        if (cmd.issue_probe) begin
            mid_reg <= mid;
        end
        if (cmd.apply_probe) begin
            if (col_below) begin
                lo_reg <= mid_reg + PTR_W'(1);
            end else begin
                hi_reg <= mid_reg;
                eq_reg <= (COL_W'(col_rd_reg) == col_reg);
            end
        end
        if (cmd.load_result) begin
            if (cmd.result_search) begin
                pos_reg    <= found ? lo_reg[POS_W-1:0] : '0;
                status_reg <= found ? STATUS_FOUND : STATUS_ABSENT;
            end else begin
                pos_reg    <= '0;
                status_reg <= cmd.result_code;
            end
        end
    end

    // search window never inverts while probing
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue_probe |-> (lo_reg < hi_reg))
        else $error("probe issued on an empty window");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply_probe |=> (lo_reg <= hi_reg) && (hi_reg <= end_reg))
        else $error("search bounds out of order");

endmodule

### design/csr_entry_position_lookup.sv
// ----------------------------------------------------------------------------
// csr_entry_position_lookup
// Sparse-row entry position lookup by binary search over stored column indices.
//
//   channel  direction  payload
//   s_       in         tuser: kind[1:0]; tdata: slot, value, row, col
//   m_       out        tuser: status[1:0]; tdata: position
//   cfg_     in         data: row_count[10:0]
//
// store writes and ignored kinds leave the sequencer idle
// a lookup reads its row offsets, probes until the window closes, then loads the result
// probes <= ceil(log2(range + 1)) <= 15; bad rows and inverted ranges are not probed
// each probe is one column store read followed by one compare
// reset clears row_count and control; stores hold garbage until written
// input stalls while a lookup runs or its result waits for an empty output register
// ----------------------------------------------------------------------------
module csr_entry_position_lookup import csrepl_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // slot[14:0], value[30:15], row[40:31], col[56:41]
    input  logic [KIND_W-1:0]   s_tuser,  // kind[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // position[13:0]
    output logic [STATUS_W-1:0] m_tuser,  // status[1:0]
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ROWCNT_W-1:0] cfg_data
);

    cmd_t             cmd;
    stat_t            stat;
    s_data_t          s_data;
    logic [POS_W-1:0] position;

    assign s_data    = s_data_t'(s_tdata);
    assign cfg_ready = 1'b1;
    assign m_tdata   = M_DATA_W'(position);

    csrepl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csrepl_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .s_kind     (s_tuser),
        .s_data     (s_data),
        .cmd        (cmd),
        .stat       (stat),
        .m_position (position),
        .m_status   (m_tuser)
    );

endmodule
